// ===== sv/bc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and register codes for the barometer compensation block
package bc_pkg;

  localparam int RawW          = 20;
  localparam int TempW         = 16;
  localparam int PressW        = 24;
  localparam int CfgIdxW       = 3;
  localparam int CfgDataW      = 48;
  localparam int QueueDepthDef = 4;
  localparam int FineW         = 25;
  localparam int DivSteps      = 64;
  localparam int DenW          = 31;
  localparam int PdiffW        = 21;
  localparam int P4Shift       = 35;

  localparam logic [PdiffW-1:0]  PdiffBase  = 21'd1048576;
  localparam logic signed [25:0] FineOffset = 26'sd128000;
  localparam logic [11:0]        NumScale   = 12'd3125;
  localparam logic signed [27:0] TempRound  = 28'sd128;
  // two to the power 47
  localparam logic signed [63:0] DivBias    = 64'sh0000_8000_0000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TEMP_1    = 3'd0,
    CFG_TEMP_2    = 3'd1,
    CFG_TEMP_3    = 3'd2,
    CFG_PRESS_1   = 3'd3,
    CFG_PRESS_2   = 3'd4,
    CFG_PRESS_3_4 = 3'd5,
    CFG_PRESS_5_6 = 3'd6,
    CFG_PRESS_7_9 = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] temp_1;
    logic [15:0] temp_2;
    logic [15:0] temp_3;
    logic [15:0] press_1;
    logic [15:0] press_2;
    logic [31:0] press_3_4;
    logic [31:0] press_5_6;
    logic [47:0] press_7_9;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    temp_1:    16'd27504,
    temp_2:    16'd26435,
    temp_3:    16'hFC18,
    press_1:   16'd36477,
    press_2:   16'hD643,
    press_3_4: 32'd187108304,
    press_5_6: 32'd4294508684,
    press_7_9: 48'd25773148486796
  };

  // one queue entry: temperature done, fine value and raw pressure for the back end
  typedef struct packed {
    logic [TempW-1:0] tc;
    logic [FineW-1:0] fine;
    logic [RawW-1:0]  adc_p;
  } entry_t;

  typedef struct packed {
    logic [TempW-1:0] tc;
    logic             invalid;
  } tag_t;

endpackage

// ===== sv/bc_ifs.sv =====
`timescale 1ns / 1ps
// Channel interfaces: raw samples in, compensated results out, register writes
interface bc_sample_if import bc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [RawW-1:0] raw_temperature;
  logic [RawW-1:0] raw_press;
  modport source (output valid, output raw_temperature, output raw_press, input ready);
  modport sink (input valid, input raw_temperature, input raw_press, output ready);
endinterface

interface bc_result_if import bc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [TempW-1:0] temperature_centi;
  logic [PressW-1:0]       pressure_pa;
  logic                    pressure_invalid;
  modport source (output valid, output temperature_centi, output pressure_pa,
                  output pressure_invalid, input ready);
  modport sink (input valid, input temperature_centi, input pressure_pa,
                input pressure_invalid, output ready);
endinterface

interface bc_cfg_if import bc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/bc_front.sv =====
`timescale 1ns / 1ps
// Front end: accept raw samples, work out fine temperature and temperature
module bc_front import bc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  cfg_t            coef,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [RawW-1:0] raw_temperature,
  input  logic [RawW-1:0] raw_press,
  input  logic            q_full,
  output logic            q_push,
  output entry_t          q_data
);

  logic adv;
  logic v1, v2, v3;

  logic signed [17:0] diff_a;
  logic signed [16:0] diff_b;
  logic signed [33:0] prod_a, prod_b;
  logic [RawW-1:0]    adc_p1, adc_p2;

  logic signed [22:0] term_a;
  logic signed [37:0] prod_c;

  logic signed [23:0] term_b;
  logic signed [24:0] fine;
  logic signed [27:0] t5;
  logic signed [19:0] tc_wide;
  logic [TempW-1:0]   tc_sat;

  // stall only when the last stage holds an item the queue cannot take
  assign adv      = !(v3 && q_full);
  assign in_ready = adv;
  assign q_push   = v3 && !q_full;

  assign diff_a = $signed(18'(raw_temperature >> 3)) - $signed(18'({coef.temp_1, 1'b0}));
  assign diff_b = $signed(17'(raw_temperature >> 4)) - $signed(17'(coef.temp_1));

  assign term_b  = prod_c[37:14];
  assign fine    = 25'(term_a) + 25'(term_b);
  assign t5      = 28'(fine) * 28'sd5 + TempRound;
  assign tc_wide = t5[27:8];

  always_comb begin
    if (tc_wide > 20'sd32767) begin
      tc_sat = 16'h7FFF;
    end else if (tc_wide < -20'sd32768) begin
      tc_sat = 16'h8000;
    end else begin
      tc_sat = tc_wide[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_a <= diff_a * $signed(coef.temp_2);
      prod_b <= diff_b * diff_b;
      adc_p1 <= raw_press;
      term_a <= prod_a[33:11];
      prod_c <= $signed(prod_b[33:12]) * $signed(coef.temp_3);
      adc_p2 <= adc_p1;
      q_data <= '{tc: tc_sat, fine: fine, adc_p: adc_p2};
    end
  end

endmodule

// ===== sv/bc_fifo.sv =====
`timescale 1ns / 1ps
// Short queue between the front and back ends
module bc_fifo import bc_pkg::*; #(
  parameter int Depth = QueueDepthDef
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_data,
  input  logic   pop,
  output entry_t pop_data,
  output logic   full,
  output logic   empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  entry_t            slots [Depth];
  logic [PtrW-1:0]   wr_ptr, rd_ptr;
  logic [CntW-1:0]   count;

  assign full     = (count == CntW'(Depth));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== sv/bc_div.sv =====
`timescale 1ns / 1ps
// Pipelined signed divider, one quotient bit per stage
module bc_div import bc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            in_valid,
  input  logic [63:0]     num,
  input  logic [DenW-1:0] den,
  input  tag_t            in_tag,
  output logic            out_valid,
  output logic [63:0]     quo,
  output logic            out_neg,
  output tag_t            out_tag
);

  logic            valid [DivSteps+1];
  logic [63:0]     dq    [DivSteps+1];
  logic [DenW-1:0] rem   [DivSteps+1];
  logic [DenW-1:0] dvs   [DivSteps+1];
  logic            neg   [DivSteps+1];
  tag_t            tag   [DivSteps+1];

  logic [DenW:0]   trial [DivSteps];
  logic            fits  [DivSteps];

  always_comb begin
    for (int k = 0; k < DivSteps; k++) begin
      trial[k] = {rem[k], dq[k][63]};
      fits[k]  = trial[k] >= {1'b0, dvs[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DivSteps; k++) begin
        valid[k] <= 1'b0;
      end
    end else if (adv) begin
      valid[0] <= in_valid;
      for (int k = 0; k < DivSteps; k++) begin
        valid[k+1] <= valid[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // take magnitudes, keep the quotient sign aside
      dq[0]  <= num[63] ? 64'(-num) : num;
      dvs[0] <= den[DenW-1] ? DenW'(-den) : den;
      rem[0] <= '0;
      neg[0] <= num[63] ^ den[DenW-1];
      tag[0] <= in_tag;
      for (int k = 0; k < DivSteps; k++) begin
        dq[k+1]  <= {dq[k][62:0], fits[k]};
        rem[k+1] <= fits[k] ? DenW'(trial[k] - {1'b0, dvs[k]}) : trial[k][DenW-1:0];
        dvs[k+1] <= dvs[k];
        neg[k+1] <= neg[k];
        tag[k+1] <= tag[k];
      end
    end
  end

  assign out_valid = valid[DivSteps];
  assign quo       = dq[DivSteps];
  assign out_neg   = neg[DivSteps];
  assign out_tag   = tag[DivSteps];

endmodule

// ===== sv/bc_back.sv =====
`timescale 1ns / 1ps
// Back end: pressure polynomial, division and output register
module bc_back import bc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  cfg_t                    coef,
  input  logic                    q_empty,
  input  entry_t                  q_data,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [TempW-1:0] temperature_centi,
  output logic [PressW-1:0]       pressure_pa,
  output logic                    pressure_invalid
);

  logic adv;
  logic signed [15:0] c_p2, c_p3, c_p4, c_p5, c_p6, c_p7, c_p8, c_p9;

  assign c_p2 = $signed(coef.press_2);
  assign c_p3 = $signed(coef.press_3_4[15:0]);
  assign c_p4 = $signed(coef.press_3_4[31:16]);
  assign c_p5 = $signed(coef.press_5_6[15:0]);
  assign c_p6 = $signed(coef.press_5_6[31:16]);
  assign c_p7 = $signed(coef.press_7_9[15:0]);
  assign c_p8 = $signed(coef.press_7_9[31:16]);
  assign c_p9 = $signed(coef.press_7_9[47:32]);

  // whole back end moves together whenever the output slot frees up
  assign adv   = !out_valid || out_ready;
  assign q_pop = adv && !q_empty;

  // stage 1
  logic               s1_v;
  logic signed [25:0] v1_in;
  logic signed [51:0] s1_sq;
  logic signed [41:0] s1_m5, s1_m2;
  logic [PdiffW-1:0]  s1_pd;
  logic [TempW-1:0]   s1_tc;
  // stage 2
  logic               s2_v;
  logic signed [67:0] a6_full, a3_full;
  logic signed [63:0] s2_a6, s2_a3;
  logic signed [41:0] s2_m5, s2_m2;
  logic [PdiffW-1:0]  s2_pd;
  logic [TempW-1:0]   s2_tc;
  // stage 3
  logic               s3_v;
  logic signed [63:0] s3_v2, s3_v1;
  logic [PdiffW-1:0]  s3_pd;
  logic [TempW-1:0]   s3_tc;
  // stage 4
  logic               s4_v;
  logic signed [63:0] biased;
  logic [79:0]        x_full;
  logic [63:0]        n0;
  logic [63:0]        s4_x, s4_n0;
  logic [TempW-1:0]   s4_tc;
  // stage 5
  logic               s5_v;
  logic [75:0]        n_full;
  logic [63:0]        s5_num;
  logic [DenW-1:0]    s5_den;
  tag_t               s5_tag;
  // divider
  logic               d_v;
  logic [63:0]        d_q;
  logic               d_neg;
  tag_t               d_tag;
  // post-division stages
  logic               c1_v, c2_v, c3_v, c4_v, c5_v;
  logic signed [63:0] c1_p, c2_p, c3_p, c4_p;
  tag_t               c1_tag, c2_tag, c3_tag, c4_tag, c5_tag;
  logic signed [66:0] t9_full;
  logic signed [79:0] t8_full;
  logic signed [63:0] c2_t9, c2_t8, c3_t8, c4_t8;
  logic signed [50:0] c2_pr;
  logic [63:0]        prx;
  logic [63:0]        ll;
  logic [31:0]        x_lh, x_hl;
  logic [63:0]        c3_ll;
  logic [31:0]        c3_x;
  logic [63:0]        c4_u;
  logic signed [63:0] sum;
  logic signed [63:0] c5_s;
  logic signed [63:0] pq, pa;
  logic [PressW-1:0]  pa_clamp;

  assign v1_in   = 26'($signed(q_data.fine)) - FineOffset;
  assign a6_full = s1_sq * c_p6;
  assign a3_full = s1_sq * c_p3;
  assign biased  = s3_v1 + DivBias;
  assign x_full  = 80'(unsigned'(biased)) * 80'(coef.press_1);
  assign n0      = (64'(s3_pd) << 31) - unsigned'(s3_v2);
  assign n_full  = 76'(s4_n0) * 76'(NumScale);

  bc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (s5_v),
    .num       (s5_num),
    .den       (s5_den),
    .in_tag    (s5_tag),
    .out_valid (d_v),
    .quo       (d_q),
    .out_neg   (d_neg),
    .out_tag   (d_tag)
  );

  assign t9_full = c_p9 * $signed(c1_p[63:13]);
  assign t8_full = c_p8 * c1_p;
  assign prx     = 64'(c2_pr);
  assign ll      = 64'(c2_t9[31:0]) * 64'(prx[31:0]);
  assign x_lh    = c2_t9[31:0] * prx[63:32];
  assign x_hl    = c2_t9[63:32] * prx[31:0];
  assign sum     = c4_p + ($signed(c4_u) >>> 25) + (c4_t8 >>> 19);
  assign pq      = c5_s + (64'(c_p7) <<< 4);
  assign pa      = pq >>> 8;

  always_comb begin
    if (pa[63]) begin
      pa_clamp = '0;
    end else if (pa > 64'sd16777215) begin
      pa_clamp = '1;
    end else begin
      pa_clamp = pa[PressW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      s4_v      <= 1'b0;
      s5_v      <= 1'b0;
      c1_v      <= 1'b0;
      c2_v      <= 1'b0;
      c3_v      <= 1'b0;
      c4_v      <= 1'b0;
      c5_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_v      <= q_pop;
      s2_v      <= s1_v;
      s3_v      <= s2_v;
      s4_v      <= s3_v;
      s5_v      <= s4_v;
      c1_v      <= d_v;
      c2_v      <= c1_v;
      c3_v      <= c2_v;
      c4_v      <= c3_v;
      c5_v      <= c4_v;
      out_valid <= c5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sq  <= v1_in * v1_in;
      s1_m5  <= v1_in * c_p5;
      s1_m2  <= v1_in * c_p2;
      s1_pd  <= PdiffBase - PdiffW'(q_data.adc_p);
      s1_tc  <= q_data.tc;

      s2_a6  <= a6_full[63:0];
      s2_a3  <= a3_full[63:0];
      s2_m5  <= s1_m5;
      s2_m2  <= s1_m2;
      s2_pd  <= s1_pd;
      s2_tc  <= s1_tc;

      s3_v2  <= s2_a6 + (64'(s2_m5) <<< 17) + (64'(c_p4) <<< P4Shift);
      s3_v1  <= (s2_a3 >>> 8) + (64'(s2_m2) <<< 12);
      s3_pd  <= s2_pd;
      s3_tc  <= s2_tc;

      s4_x   <= x_full[63:0];
      s4_n0  <= n0;
      s4_tc  <= s3_tc;

      // divisor is the top bits of the scaled sum; zero marks the pressure invalid
      s5_den <= s4_x[63:33];
      s5_num <= n_full[63:0];
      s5_tag <= '{tc: s4_tc, invalid: (s4_x[63:33] == '0)};

      c1_p   <= d_neg ? $signed(-d_q) : $signed(d_q);
      c1_tag <= d_tag;

      c2_t9  <= t9_full[63:0];
      c2_t8  <= t8_full[63:0];
      c2_pr  <= c1_p[63:13];
      c2_p   <= c1_p;
      c2_tag <= c1_tag;

      c3_ll  <= ll;
      c3_x   <= x_lh + x_hl;
      c3_t8  <= c2_t8;
      c3_p   <= c2_p;
      c3_tag <= c2_tag;

      c4_u   <= c3_ll + {c3_x, 32'b0};
      c4_t8  <= c3_t8;
      c4_p   <= c3_p;
      c4_tag <= c3_tag;

      c5_s   <= sum >>> 8;
      c5_tag <= c4_tag;

      temperature_centi <= $signed(c5_tag.tc);
      pressure_pa       <= c5_tag.invalid ? '0 : pa_clamp;
      pressure_invalid  <= c5_tag.invalid;
    end
  end

endmodule

// ===== sv/barometer_compensation.sv =====
`timescale 1ns / 1ps
// Throughput: one sample per cycle unless the result side or a full queue stalls;
//   pipelined divider and single-issue front and back pipelines move one a cycle.
// Reset (rst, synchronous, active high): empties all pipelines and the queue and
//   loads the calibration words with their default values.
module barometer_compensation import bc_pkg::*; #(
  parameter int QueueDepth = QueueDepthDef
) (
  input logic           clk,
  input logic           rst,
  bc_cfg_if.sink        cfg,
  bc_sample_if.sink     sample,
  bc_result_if.source   result
);

  cfg_t   coef;
  logic   q_push, q_pop, q_full, q_empty;
  entry_t q_in, q_out;

  // Register writes are always taken; an index outside the list changes nothing.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= CfgReset;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg_idx_t'(cfg.index))
        CFG_TEMP_1:    coef.temp_1    <= cfg.data[15:0];
        CFG_TEMP_2:    coef.temp_2    <= cfg.data[15:0];
        CFG_TEMP_3:    coef.temp_3    <= cfg.data[15:0];
        CFG_PRESS_1:   coef.press_1   <= cfg.data[15:0];
        CFG_PRESS_2:   coef.press_2   <= cfg.data[15:0];
        CFG_PRESS_3_4: coef.press_3_4 <= cfg.data[31:0];
        CFG_PRESS_5_6: coef.press_5_6 <= cfg.data[31:0];
        CFG_PRESS_7_9: coef.press_7_9 <= cfg.data[47:0];
        default: ;
      endcase
    end
  end

  // Front end: take each sample transaction, finish the temperature and fine value.
  bc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .coef            (coef),
    .in_valid        (sample.valid),
    .in_ready        (sample.ready),
    .raw_temperature (sample.raw_temperature),
    .raw_press       (sample.raw_press),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_data          (q_in)
  );

  // Queue: lets the front keep accepting while the back waits on the result side.
  bc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Back end: pressure polynomial, divide, scale and clamp; hold the result
  // in its output register until the result transaction completes.
  bc_back u_back (
    .clk               (clk),
    .rst               (rst),
    .coef              (coef),
    .q_empty           (q_empty),
    .q_data            (q_out),
    .q_pop             (q_pop),
    .out_valid         (result.valid),
    .out_ready         (result.ready),
    .temperature_centi (result.temperature_centi),
    .pressure_pa       (result.pressure_pa),
    .pressure_invalid  (result.pressure_invalid)
  );

endmodule
